@@ rtl/core/bracket_frame_relay_command_decoder_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef BRACKET_FRAME_RELAY_COMMAND_DECODER_DEFINES_SVH
`define BRACKET_FRAME_RELAY_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFRCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFRCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/bfrcd_pkg.sv @@
package bfrcd_pkg;

  localparam logic [7:0] OPEN_BYTE  = 8'h5B;
  localparam logic [7:0] CLOSE_BYTE = 8'h5D;

  localparam logic [4:0] MIN_FRAME = 5'd4;
  localparam logic [4:0] MAX_FRAME = 5'd10;
  localparam logic [3:0] COUNT_TOP = 4'd15;

  // Command byte pairs: first byte selects the target, second the action.
  localparam logic [7:0] CMD_RELAY_ONE = 8'h01;
  localparam logic [7:0] CMD_RELAY_TWO = 8'h02;
  localparam logic [7:0] CMD_AUTO      = 8'h03;
  localparam logic [7:0] ARG_SET       = 8'h03;
  localparam logic [7:0] ARG_CLEAR     = 8'h04;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] first;
    logic [7:0] second;
  } frame_evt_t;

  typedef struct packed {
    logic relay_one;
    logic relay_two;
    logic auto_en;
  } relay_lvl_t;

endpackage

@@ rtl/core/bfrcd_frame.sv @@
module bfrcd_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output bfrcd_pkg::frame_evt_t evt
);

  logic       in_frame_r, in_frame_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [4:0] total;

  assign total = {1'b0, count_r} + 5'd1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    evt.status   = bfrcd_pkg::ST_NONE;
    evt.first    = first_r;
    evt.second   = second_r;
    if (!in_frame_r) begin
      if (rx_byte == bfrcd_pkg::OPEN_BYTE) begin
        in_frame_nxt = 1'b1;
        count_nxt    = 4'd1;
        xor_nxt      = 8'h00;
        first_nxt    = 8'h00;
        second_nxt   = 8'h00;
      end
    end else if (rx_byte == bfrcd_pkg::CLOSE_BYTE) begin
      // Length is checked ahead of the checksum.
      if (total < bfrcd_pkg::MIN_FRAME || total > bfrcd_pkg::MAX_FRAME) begin
        evt.status = bfrcd_pkg::ST_BAD_LEN;
      end else if (xor_r != 8'h00) begin
        evt.status = bfrcd_pkg::ST_BAD_SUM;
      end else begin
        evt.status = bfrcd_pkg::ST_ACCEPT;
      end
      in_frame_nxt = 1'b0;
      count_nxt    = 4'd0;
      xor_nxt      = 8'h00;
    end else begin
      if (count_r == 4'd1) begin
        first_nxt = rx_byte;
      end else if (count_r == 4'd2) begin
        second_nxt = rx_byte;
      end
      xor_nxt = xor_r ^ rx_byte;
      if (count_r < bfrcd_pkg::COUNT_TOP) begin
        count_nxt = count_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= 4'd0;
      xor_r      <= 8'h00;
      first_r    <= 8'h00;
      second_r   <= 8'h00;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      xor_r      <= xor_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
    end
  end

endmodule

@@ rtl/core/bfrcd_relay.sv @@
module bfrcd_relay (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  bfrcd_pkg::frame_evt_t evt,
  output bfrcd_pkg::relay_lvl_t lvl_nxt
);

  bfrcd_pkg::relay_lvl_t lvl_r;
  logic                  accept;

  assign accept = (evt.status == bfrcd_pkg::ST_ACCEPT);

  always_comb begin
    lvl_nxt = lvl_r;
    if (accept) begin
      // Relay commands are gated by the auto flag as it stood before this frame.
      if (lvl_r.auto_en) begin
        if (evt.first == bfrcd_pkg::CMD_RELAY_ONE && evt.second == bfrcd_pkg::ARG_SET) begin
          lvl_nxt.relay_one = 1'b1;
        end else if (evt.first == bfrcd_pkg::CMD_RELAY_ONE &&
                     evt.second == bfrcd_pkg::ARG_CLEAR) begin
          lvl_nxt.relay_one = 1'b0;
        end
        if (evt.first == bfrcd_pkg::CMD_RELAY_TWO && evt.second == bfrcd_pkg::ARG_SET) begin
          lvl_nxt.relay_two = 1'b1;
        end else if (evt.first == bfrcd_pkg::CMD_RELAY_TWO &&
                     evt.second == bfrcd_pkg::ARG_CLEAR) begin
          lvl_nxt.relay_two = 1'b0;
        end
      end
      if (evt.first == bfrcd_pkg::CMD_AUTO && evt.second == bfrcd_pkg::ARG_SET) begin
        lvl_nxt.auto_en = 1'b1;
      end else if (evt.first == bfrcd_pkg::CMD_AUTO && evt.second == bfrcd_pkg::ARG_CLEAR) begin
        lvl_nxt.auto_en = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (step) begin
      lvl_r <= lvl_nxt;
    end
  end

endmodule

@@ rtl/core/bracket_frame_relay_command_decoder.sv @@
// Bracket-framed relay command decoder. Each accepted byte yields exactly one
// result carrying the relay and auto levels after that byte plus a frame status
// (none, accepted, bad checksum, bad length). A byte sits in an input register,
// is decoded combinationally against the frame state and lands in the result
// register once the result slot is free, and one byte per cycle is sustained
// while out_ready stays high. The input register can still take a byte while
// a finished result waits; in_ready drops only when both registers are full.
module bracket_frame_relay_command_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_relay_one,
  output logic       out_relay_two,
  output logic       out_auto_enabled,
  output logic [1:0] out_frame_status
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  out_vld_r;
  bfrcd_pkg::relay_lvl_t out_lvl_r;
  bfrcd_pkg::status_t    out_status_r;
  logic                  adv;
  bfrcd_pkg::frame_evt_t evt;
  bfrcd_pkg::relay_lvl_t lvl_nxt;

  // The decode step runs whenever a byte is held and the result slot is free.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  bfrcd_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .evt     (evt)
  );

  bfrcd_relay u_relay (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .evt     (evt),
    .lvl_nxt (lvl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv) begin
      out_lvl_r    <= lvl_nxt;
      out_status_r <= evt.status;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_relay_one    = out_lvl_r.relay_one;
  assign out_relay_two    = out_lvl_r.relay_two;
  assign out_auto_enabled = out_lvl_r.auto_en;
  assign out_frame_status = out_status_r;

endmodule

@@ rtl/core/bfrcd_checker.sv @@
`include "bracket_frame_relay_command_decoder_defines.svh"

module bfrcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_relay_one,
  input logic       out_relay_two,
  input logic       out_auto_enabled,
  input logic [1:0] out_frame_status
);

  logic       seen_r;
  logic [2:0] last_lvl_r;
  logic       not_accept;
  logic       relay_moved;
  logic [4:0] out_word;

  assign out_word    = {out_relay_one, out_relay_two, out_auto_enabled, out_frame_status};
  assign not_accept  = (out_frame_status != bfrcd_pkg::ST_ACCEPT);
  assign relay_moved = (out_relay_one != last_lvl_r[2]) || (out_relay_two != last_lvl_r[1]);

  // Levels of the last delivered result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      last_lvl_r <= 3'b000;
    end else if (out_valid && out_ready) begin
      seen_r     <= 1'b1;
      last_lvl_r <= {out_relay_one, out_relay_two, out_auto_enabled};
    end
  end

  `BFRCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
  `BFRCD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid && !out_ready)
  `BFRCD_ASSERT_NOW(a_levels_only_on_accept, clk, rst_n, out_valid && seen_r && not_accept, out_word[4:2] == last_lvl_r)
  `BFRCD_ASSERT_NOW(a_relay_needs_auto, clk, rst_n, out_valid && seen_r && relay_moved, last_lvl_r[0])

endmodule

bind bracket_frame_relay_command_decoder bfrcd_checker u_bfrcd_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT = 1000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic               relay_one;
    logic               relay_two;
    logic               auto_en;
    bfrcd_pkg::status_t status;
  } relay_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_relay_one;
  logic       out_relay_two;
  logic       out_auto_enabled;
  logic [1:0] out_frame_status;

  // Shadow copy of the decoder state, advanced once per accepted byte.
  logic       frm_open = 1'b0;
  logic [3:0] frm_len = 4'd0;
  logic [7:0] frm_sum = 8'h00;
  logic [7:0] frm_cmd = 8'h00;
  logic [7:0] frm_arg = 8'h00;
  logic       lvl_relay_one = 1'b0;
  logic       lvl_relay_two = 1'b0;
  logic       lvl_auto = 1'b0;

  relay_report_t pending_reports[$];
  relay_report_t want;
  int            errors = 0;
  int            bytes_sent = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;
  bit            back_to_back = 1'b0;

  bracket_frame_relay_command_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_relay_one    (out_relay_one),
    .out_relay_two    (out_relay_two),
    .out_auto_enabled (out_auto_enabled),
    .out_frame_status (out_frame_status)
  );

  always #5 clk = ~clk;

  function automatic relay_report_t decode_rx_byte(input logic [7:0] b);
    relay_report_t rpt;
    logic [4:0]    total;
    logic          gate;
    logic          cmd_one;
    logic          cmd_two;
    logic          cmd_auto;
    rpt.status = bfrcd_pkg::ST_NONE;
    if (!frm_open) begin
      if (b == bfrcd_pkg::OPEN_BYTE) begin
        frm_open = 1'b1;
        frm_len  = 4'd1;
        frm_sum  = 8'h00;
        frm_cmd  = 8'h00;
        frm_arg  = 8'h00;
      end
    end else if (b == bfrcd_pkg::CLOSE_BYTE) begin
      total = {1'b0, frm_len} + 5'd1;
      if (total < bfrcd_pkg::MIN_FRAME || total > bfrcd_pkg::MAX_FRAME) begin
        rpt.status = bfrcd_pkg::ST_BAD_LEN;
      end else if (frm_sum != 8'h00) begin
        rpt.status = bfrcd_pkg::ST_BAD_SUM;
      end else begin
        rpt.status = bfrcd_pkg::ST_ACCEPT;
        // Relay commands only act if auto was on before this frame.
        gate     = lvl_auto;
        cmd_one  = (frm_cmd == bfrcd_pkg::CMD_RELAY_ONE);
        cmd_two  = (frm_cmd == bfrcd_pkg::CMD_RELAY_TWO);
        cmd_auto = (frm_cmd == bfrcd_pkg::CMD_AUTO);
        if (gate && cmd_one && frm_arg == bfrcd_pkg::ARG_SET) lvl_relay_one = 1'b1;
        if (gate && cmd_one && frm_arg == bfrcd_pkg::ARG_CLEAR) lvl_relay_one = 1'b0;
        if (gate && cmd_two && frm_arg == bfrcd_pkg::ARG_SET) lvl_relay_two = 1'b1;
        if (gate && cmd_two && frm_arg == bfrcd_pkg::ARG_CLEAR) lvl_relay_two = 1'b0;
        if (cmd_auto && frm_arg == bfrcd_pkg::ARG_SET) lvl_auto = 1'b1;
        if (cmd_auto && frm_arg == bfrcd_pkg::ARG_CLEAR) lvl_auto = 1'b0;
      end
      frm_open = 1'b0;
      frm_len  = 4'd0;
      frm_sum  = 8'h00;
    end else begin
      if (frm_len == 4'd1) begin
        frm_cmd = b;
      end else if (frm_len == 4'd2) begin
        frm_arg = b;
      end
      frm_sum = frm_sum ^ b;
      if (frm_len < bfrcd_pkg::COUNT_TOP) frm_len = frm_len + 4'd1;
    end
    rpt.relay_one = lvl_relay_one;
    rpt.relay_two = lvl_relay_two;
    rpt.auto_en   = lvl_auto;
    return rpt;
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Result side: check every transaction, then hold ready low for a random stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result with no byte pending, expected none actual %0b%0b%0b/%0d",
                   $time, out_relay_one, out_relay_two, out_auto_enabled, out_frame_status);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("relay_one", want.relay_one, out_relay_one);
          check_field("relay_two", want.relay_two, out_relay_two);
          check_field("auto_enabled", want.auto_en, out_auto_enabled);
          check_field("frame_status", want.status, out_frame_status);
        end
        stall_left = back_to_back ? 0 : $urandom_range(0, 14);
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left = stall_left - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(decode_rx_byte(b));
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t body);
    send_byte(bfrcd_pkg::OPEN_BYTE);
    foreach (body[i]) send_byte(body[i]);
    send_byte(bfrcd_pkg::CLOSE_BYTE);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == bfrcd_pkg::CLOSE_BYTE);
    return b;
  endfunction

  // Command, argument, random padding, then the checksum byte that zeroes the XOR.
  function automatic byte_q_t command_body(input logic [7:0] cmd, input logic [7:0] arg,
                                           input int pad);
    byte_q_t    body;
    logic [7:0] sum;
    body = '{cmd, arg};
    for (int i = 0; i < pad; i++) body.push_back(payload_byte());
    sum = 8'h00;
    foreach (body[i]) sum = sum ^ body[i];
    while (pad > 0 && sum == bfrcd_pkg::CLOSE_BYTE) begin
      sum = sum ^ body[$];
      body[$] = payload_byte();
      sum = sum ^ body[$];
    end
    body.push_back(sum);
    return body;
  endfunction

  task automatic test_stray_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(bfrcd_pkg::CLOSE_BYTE);
  endtask

  task automatic test_auto_gate();
    // Relay command while auto is off: accepted but ignored.
    send_frame(command_body(bfrcd_pkg::CMD_RELAY_ONE, bfrcd_pkg::ARG_SET, 0));
    // Shortest frame: the checksum byte doubles as the argument.
    send_frame('{bfrcd_pkg::CMD_AUTO, bfrcd_pkg::ARG_SET});
    send_frame(command_body(bfrcd_pkg::CMD_RELAY_ONE, bfrcd_pkg::ARG_SET, 0));
    // An open bracket inside a frame is plain payload.
    send_frame('{bfrcd_pkg::CMD_RELAY_TWO, bfrcd_pkg::ARG_SET, bfrcd_pkg::OPEN_BYTE, 8'h5A});
  endtask

  task automatic test_checksum_error();
    send_frame('{bfrcd_pkg::CMD_AUTO, bfrcd_pkg::ARG_CLEAR, 8'h00});
  endtask

  task automatic test_length_discard();
    byte_q_t empty_body;
    empty_body = {};
    send_frame(empty_body);
    send_frame('{8'hFF});
    // One byte over the limit with a good checksum: length wins.
    send_frame(command_body(bfrcd_pkg::CMD_AUTO, bfrcd_pkg::ARG_CLEAR, 6));
  endtask

  task automatic test_drain_pause();
    send_frame(command_body(bfrcd_pkg::CMD_RELAY_ONE, bfrcd_pkg::ARG_CLEAR, 1));
    wait_drained();
    send_frame(command_body(bfrcd_pkg::CMD_RELAY_TWO, bfrcd_pkg::ARG_CLEAR, 2));
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int         stop_at;
    int         kind;
    int         pick;
    logic [7:0] cmd;
    logic [7:0] arg;
    byte_q_t    body;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) back_to_back = ~back_to_back;
      pick = $urandom_range(0, 9);
      cmd = (pick < 3) ? bfrcd_pkg::CMD_RELAY_ONE : (pick < 6) ? bfrcd_pkg::CMD_RELAY_TWO :
            (pick < 9) ? bfrcd_pkg::CMD_AUTO : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      arg = (pick < 5) ? bfrcd_pkg::ARG_SET : (pick < 9) ? bfrcd_pkg::ARG_CLEAR :
            8'($urandom_range(0, 255));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(command_body(cmd, arg, $urandom_range(0, 5)));
      end else if (kind < 62) begin
        cmd = ($urandom_range(0, 1) == 0) ? bfrcd_pkg::CMD_AUTO : payload_byte();
        send_frame('{cmd, cmd});
      end else if (kind < 72) begin
        body = command_body(cmd, arg, $urandom_range(0, 5));
        body[$] = body[$] ^ 8'($urandom_range(1, 255));
        send_frame(body);
      end else if (kind < 77) begin
        body = {};
        repeat ($urandom_range(0, 1)) body.push_back(payload_byte());
        send_frame(body);
      end else if (kind < 85) begin
        // Too long; sometimes long enough to saturate the byte count.
        send_frame(command_body(cmd, arg, $urandom_range(6, 16)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_bytes();
    test_auto_gate();
    test_checksum_error();
    test_length_discard();
    test_drain_pause();
    test_random_traffic(490);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bfrcd_pkg.sv
rtl/core/bfrcd_frame.sv
rtl/core/bfrcd_relay.sv
rtl/core/bracket_frame_relay_command_decoder.sv
rtl/core/bfrcd_checker.sv
tb/sv/tb.sv
